[sv/wct_pkg.sv]
package wct_pkg;

   localparam int unsigned CsrIndexWidth = 3;

   localparam logic [16:0] Q16_ONE   = 17'h10000;
   localparam logic [16:0] Q16_ZERO  = 17'h00000;
   localparam logic [31:0] GAIN_HALF = 32'h0000_8000;

   localparam logic [1:0] KIND_TICK      = 2'd0;
   localparam logic [1:0] KIND_OBJECTIVE = 2'd1;
   localparam logic [1:0] KIND_GAIN      = 2'd2;

   localparam logic [CsrIndexWidth-1:0] CSR_FALLS_EXPECTED = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_HORIZON        = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_RATE_ALPHA     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_RATE_FORGET    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_PRIOR_LEVEL    = 3'd4;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] sample;
      logic [63:0]        tick_number;
   } req_type;

   typedef struct packed {
      logic [63:0] tick_echo;
      logic [16:0] competence;
      logic [16:0] error_level;
      logic        is_driving;
      logic [31:0] check_total;
      logic [31:0] improve_total;
   } rsp_type;

   typedef struct packed {
      logic        falls_expected;
      logic [15:0] horizon;
      logic [16:0] rate_alpha;
      logic [16:0] rate_forget;
      logic [16:0] prior_level;
   } cfg_type;

   function automatic logic [16:0] cap_one(input logic [16:0] v);
      return (v > Q16_ONE) ? Q16_ONE : v;
   endfunction

endpackage

[sv/wct_csr.sv]
module wct_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wct_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [16:0]                         csr_wdata,
   output wct_pkg::cfg_type                    cfg
);
   import wct_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FALLS_EXPECTED: cfg_in.falls_expected = csr_wdata[0];
            CSR_HORIZON:        cfg_in.horizon        = csr_wdata[15:0];
            CSR_RATE_ALPHA:     cfg_in.rate_alpha     = csr_wdata;
            CSR_RATE_FORGET:    cfg_in.rate_forget    = csr_wdata;
            CSR_PRIOR_LEVEL:    cfg_in.prior_level    = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.falls_expected <= 1'b0;
         cfg_ff.horizon        <= 16'd30;
         cfg_ff.rate_alpha     <= 17'd3277;
         cfg_ff.rate_forget    <= 17'd66;
         cfg_ff.prior_level    <= 17'd32768;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[sv/wct_ema.sv]
module wct_ema (
   input  logic [16:0] level,
   input  logic [16:0] target,
   input  logic [16:0] rate,
   output logic [16:0] level_next
);
   import wct_pkg::*;

   logic signed [17:0] diff;
   logic signed [35:0] prod;
   logic signed [19:0] step;
   logic signed [20:0] sum;

   assign diff = $signed({1'b0, target}) - $signed({1'b0, level});
   assign prod = $signed({1'b0, rate}) * diff;
   // upper bits of the product: arithmetic shift, rounds toward minus infinity
   assign step = prod[35:16];
   assign sum  = $signed({4'b0000, level}) + $signed({step[19], step});

   always_comb begin
      if (sum[20]) begin
         level_next = Q16_ZERO;
      end else if (sum > $signed({4'b0000, Q16_ONE})) begin
         level_next = Q16_ONE;
      end else begin
         level_next = sum[16:0];
      end
   end

endmodule

[sv/wct_core.sv]
module wct_core (
   input  logic              clock,
   input  logic              reset,
   input  wct_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  wct_pkg::req_type  req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wct_pkg::rsp_type  rsp_item
);
   import wct_pkg::*;

   logic        in_valid_ff, in_valid_in;
   req_type     in_item_ff, in_item_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_item_ff, out_item_in;

   logic [16:0] competence_ff, competence_in;
   logic [31:0] objective_ff, objective_in;
   logic        objective_seen_ff, objective_seen_in;
   logic [31:0] gain_ff, gain_in;
   logic        was_driving_ff, was_driving_in;
   logic [15:0] window_count_ff, window_count_in;
   logic [31:0] window_start_ff, window_start_in;
   logic [31:0] checks_ff, checks_in;
   logic [31:0] improves_ff, improves_in;

   logic        is_tick;
   logic        out_free;
   logic        fire;
   logic        fire_tick;
   logic        drive;
   logic [15:0] h_eff;
   logic [15:0] count_base;
   logic [31:0] start_base;
   logic [16:0] count_inc;
   logic        check;
   logic signed [32:0] obj_diff;
   logic        improved;
   logic [16:0] ema_target;
   logic [16:0] ema_rate;
   logic [16:0] ema_result;

   assign is_tick   = (in_item_ff.kind == KIND_TICK);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && (!is_tick || out_free);
   assign fire_tick = fire && is_tick;
   assign req_stall = in_valid_ff && !fire;

   assign drive = ($signed(gain_ff) > $signed(GAIN_HALF)) && objective_seen_ff;
   assign h_eff = (cfg.horizon == 16'd0) ? 16'd1 : cfg.horizon;

   // a window restarts at the current objective when driving begins
   assign count_base = was_driving_ff ? window_count_ff : 16'd0;
   assign start_base = was_driving_ff ? window_start_ff : objective_ff;
   assign count_inc  = {1'b0, count_base} + 17'd1;
   assign check      = drive && (count_inc >= {1'b0, h_eff});

   assign obj_diff = $signed({objective_ff[31], objective_ff})
                   - $signed({start_base[31], start_base});
   assign improved = cfg.falls_expected ? obj_diff[32]
                                        : (!obj_diff[32] && (obj_diff != 33'sd0));

   assign ema_target = drive ? (improved ? Q16_ONE : Q16_ZERO) : cap_one(cfg.prior_level);
   assign ema_rate   = drive ? cap_one(cfg.rate_alpha) : cap_one(cfg.rate_forget);

   wct_ema u_ema (
      .level      (competence_ff),
      .target     (ema_target),
      .rate       (ema_rate),
      .level_next (ema_result)
   );

   always_comb begin
      in_valid_in       = in_valid_ff;
      in_item_in        = in_item_ff;
      competence_in     = competence_ff;
      objective_in      = objective_ff;
      objective_seen_in = objective_seen_ff;
      gain_in           = gain_ff;
      was_driving_in    = was_driving_ff;
      window_count_in   = window_count_ff;
      window_start_in   = window_start_ff;
      checks_in         = checks_ff;
      improves_in       = improves_ff;
      out_valid_in      = out_valid_ff && rsp_stall;
      out_item_in       = out_item_ff;

      if (fire) begin
         in_valid_in = 1'b0;
         case (in_item_ff.kind)
            KIND_OBJECTIVE: begin
               objective_in      = in_item_ff.sample;
               objective_seen_in = 1'b1;
            end
            KIND_GAIN: begin
               gain_in = in_item_ff.sample;
            end
            KIND_TICK: begin
               was_driving_in = drive;
               if (drive) begin
                  if (check) begin
                     window_count_in = 16'd0;
                     window_start_in = objective_ff;
                     checks_in       = checks_ff + 32'd1;
                     improves_in     = improves_ff + {31'd0, improved};
                     competence_in   = ema_result;
                  end else begin
                     window_count_in = count_inc[15:0];
                     window_start_in = start_base;
                  end
               end else begin
                  competence_in = ema_result;
               end
               out_valid_in              = 1'b1;
               out_item_in.tick_echo     = in_item_ff.tick_number;
               out_item_in.competence    = competence_in;
               out_item_in.error_level   = Q16_ONE - competence_in;
               out_item_in.is_driving    = drive;
               out_item_in.check_total   = checks_in;
               out_item_in.improve_total = improves_in;
            end
            default: begin
               in_valid_in = 1'b0;
            end
         endcase
      end

      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         competence_ff     <= 17'd32768;
         objective_ff      <= 32'd0;
         objective_seen_ff <= 1'b0;
         gain_ff           <= 32'd0;
         was_driving_ff    <= 1'b0;
         window_count_ff   <= 16'd0;
         window_start_ff   <= 32'd0;
         checks_ff         <= 32'd0;
         improves_ff       <= 32'd0;
      end else begin
         in_valid_ff       <= in_valid_in;
         out_valid_ff      <= out_valid_in;
         competence_ff     <= competence_in;
         objective_ff      <= objective_in;
         objective_seen_ff <= objective_seen_in;
         gain_ff           <= gain_in;
         was_driving_ff    <= was_driving_in;
         window_count_ff   <= window_count_in;
         window_start_ff   <= window_start_in;
         checks_ff         <= checks_in;
         improves_ff       <= improves_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   a_competence_range: assert property (@(posedge clock) disable iff (reset)
      competence_ff <= Q16_ONE)
      else $error("competence above one");

   a_stall_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && is_tick))
      else $error("input stalled behind a sample");

   a_sample_keeps_counts: assert property (@(posedge clock) disable iff (reset)
      (fire && !is_tick) |=> ($stable(checks_ff) && $stable(competence_ff)))
      else $error("sample item changed competence or check count");

   a_result_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(fire_tick))
      else $error("result without a tick");

   a_window_below_horizon: assert property (@(posedge clock) disable iff (reset)
      (fire_tick && drive) |=> (window_count_ff < $past(h_eff)))
      else $error("window count passed horizon");

endmodule

[sv/windowed_competence_tracker.sv]
// A tick is accepted into the input register, then its result goes to the output register,
// with rsp_valid high. Samples produce no result.
// Throughput: one item per cycle. A tick waits in the input register, and so stalls the
// input, only while the output register holds a result whose stall is high.
// Reset (synchronous, active high) empties both registers, loads the register reset values
// and sets competence to 0.5.
module windowed_competence_tracker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  wct_pkg::req_type                   req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output wct_pkg::rsp_type                   rsp_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wct_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [16:0]                        csr_wdata
);
   import wct_pkg::*;

   cfg_type cfg;

   wct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wct_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
